### rtl/apra_pkg.sv
// Shared constants, types and helpers for the aligned page run allocator.
// No dependencies; imported by apra_map, the top level and the testbench.
`default_nettype none
package apra_pkg;

  localparam int MAX_PAGES = 1024;
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;
  localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PAGE_W    = $clog2(MAX_PAGES);
  // page positions, with headroom for rounded-up starts plus a count
  localparam int POS_W     = PAGE_W + 2;
  localparam int HI_W      = POS_W - BIT_W;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_INIT  = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_NO_RUN = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;

  localparam logic [0:0] CFG_TOTAL    = 1'd0;
  localparam logic [0:0] CFG_RESERVED = 1'd1;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [WORD_W-1:0] addr;
    word_t             wdata;
  } map_req_t;

  function automatic logic [POS_W-1:0] round_up(input logic [POS_W-1:0] v,
                                                 input logic [POS_W-1:0] a);
    round_up = (v + a - POS_W'(1)) & ~(a - POS_W'(1));
  endfunction

  // bits of word w that lie in pages first..last
  function automatic word_t run_mask(input logic [WORD_W-1:0] w,
                                     input logic [POS_W-1:0] first,
                                     input logic [POS_W-1:0] last);
    logic [BIT_W-1:0] lo;
    logic [BIT_W-1:0] hi;
    lo = (HI_W'(w) == first[POS_W-1:BIT_W]) ? first[BIT_W-1:0] : '0;
    hi = (HI_W'(w) == last[POS_W-1:BIT_W])  ? last[BIT_W-1:0]  : '1;
    run_mask = ({WORD_BITS{1'b1}} << lo) & ({WORD_BITS{1'b1}} >> (~hi));
  endfunction

  // bit position of the lowest set bit
  function automatic logic [BIT_W-1:0] lowest_set(input word_t v);
    word_t            one_hot;
    logic [BIT_W-1:0] idx;
    one_hot = v & (~v + WORD_BITS'(1));
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (one_hot[i]) idx = idx | BIT_W'(i);
    end
    lowest_set = idx;
  endfunction

endpackage
`default_nettype wire

### rtl/aligned_page_run_allocator.sv
// Top level of the aligned page run allocator: request sequencer and counters.
// Depends on apra_pkg and apra_map (which holds apra_ram).
`default_nettype none
// Usage
//   A request beat is taken at a clock edge with start high and busy low:
//   req_type selects allocate, free or init; page_count, run_align and
//   page_index carry the operands. Every request yields one result beat:
//   done is high for exactly one cycle with status, start_page and the
//   counter snapshots. The receiver cannot stall; the result is lost if
//   not captured in that cycle. busy is low in the done cycle, so a new
//   request may be issued then.
//   Sequencing: rejected requests and allocates whose first aligned run
//   already lies beyond the pool answer in the cycle after the request.
//   An allocate walks the used map one 64-page word at a time, reading
//   it from the RAM and then examining it; every used page met restarts
//   the walk at the next aligned candidate. Marking then reads, modifies
//   and writes back each word of the run; a free does the same over its
//   run's words. Init writes every map word once. The single map port
//   serialises all of these steps. Reset: map reads as all free (per-word
//   valid bits), counters zero, total_pages 1024, reserved_pages 1.
//   Reserved pages are marked only by init. The user must write configuration
//   (cfg_we/cfg_index/cfg_data) only while idle; the block does not enforce it.
module aligned_page_run_allocator
  import apra_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [10:0] page_count,
  input  wire logic [10:0] run_align,
  input  wire logic [9:0]  page_index,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [10:0] cfg_data,
  output logic             done,
  output logic [1:0]       status,
  output logic [9:0]       start_page,
  output logic [10:0]      used_page_total,
  output logic [31:0]      alloc_total,
  output logic [31:0]      free_total
);

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_EX, S_MARK_RD, S_MARK_WR, S_INIT
  } state_t;

  state_t            state;
  logic [10:0]       total_pages;
  logic [9:0]        reserved_pages;
  logic [POS_W-1:0]  at;        // current candidate run start
  logic [POS_W-1:0]  pos;       // scan position within candidate
  logic [POS_W-1:0]  cnt;
  logic [POS_W-1:0]  align;
  logic [WORD_W-1:0] wcur;
  logic              op_set;    // 1 marks run used, 0 clears it
  logic [10:0]       used_pages;
  logic [31:0]       alloc_counter;
  logic [31:0]       free_counter;

  map_req_t          map_req;
  word_t             map_rdata;

  apra_map u_map (
    .clk  (clk),
    .rst  (rst),
    .req  (map_req),
    .rdata(map_rdata)
  );

  // effective pool size and init reservation
  logic [POS_W-1:0] limit;
  logic [POS_W-1:0] resv;
  logic [POS_W-1:0] init_r;
  assign limit  = (POS_W'(total_pages) > POS_W'(MAX_PAGES)) ? POS_W'(MAX_PAGES)
                                                           : POS_W'(total_pages);
  assign resv   = POS_W'(reserved_pages);
  assign init_r = (resv < limit) ? resv : limit;

  // request checks at accept time
  logic [POS_W-1:0] cnt_in;
  logic [POS_W-1:0] align_in;
  logic [POS_W-1:0] idx_in;
  logic [POS_W-1:0] at0;
  logic             alloc_ok;
  logic             free_ok;
  assign cnt_in   = POS_W'(page_count);
  assign align_in = POS_W'(run_align);
  assign idx_in   = POS_W'(page_index);
  assign alloc_ok = (cnt_in != '0) && (align_in != '0) &&
                    ((align_in & (align_in - POS_W'(1))) == '0);
  assign at0      = round_up(resv, align_in);
  assign free_ok  = (cnt_in != '0) && (idx_in < limit) && (idx_in + cnt_in <= limit);

  // scan of one map word
  logic [POS_W-1:0]  last;
  logic [WORD_W-1:0] pos_word;
  logic [WORD_W-1:0] last_word;
  word_t             hits;
  logic [POS_W-1:0]  hit_page;
  logic [POS_W-1:0]  next_at;
  assign last      = at + cnt - POS_W'(1);
  assign pos_word  = pos[BIT_W+WORD_W-1:BIT_W];
  assign last_word = last[BIT_W+WORD_W-1:BIT_W];
  assign hits      = map_rdata & run_mask(pos_word, pos, last);
  assign hit_page  = {pos[POS_W-1:BIT_W], lowest_set(hits)};
  assign next_at   = round_up(hit_page + POS_W'(1), align);

  // saturating used-count updates
  logic [POS_W-1:0] used_add;
  logic [10:0]      used_inc;
  logic [10:0]      used_dec;
  assign used_add = POS_W'(used_pages) + cnt;
  assign used_inc = (used_add > POS_W'(2047)) ? 11'd2047 : used_add[10:0];
  assign used_dec = (POS_W'(used_pages) > cnt) ? 11'(POS_W'(used_pages) - cnt) : '0;

  // init content of word wcur: pages below init_r
  word_t init_word;
  always_comb begin
    if (init_r[POS_W-1:BIT_W] > HI_W'(wcur))       init_word = '1;
    else if (init_r[POS_W-1:BIT_W] == HI_W'(wcur)) init_word = ~('1 << init_r[BIT_W-1:0]);
    else                                           init_word = '0;
  end

  always_comb begin
    map_req = '0;
    case (state)
      S_SRCH_RD: begin
        map_req.rd_en = 1'b1;
        map_req.addr  = pos_word;
      end
      S_MARK_RD: begin
        map_req.rd_en = 1'b1;
        map_req.addr  = wcur;
      end
      S_MARK_WR: begin
        map_req.wr_en = 1'b1;
        map_req.addr  = wcur;
        map_req.wdata = op_set ? (map_rdata | run_mask(wcur, at, last))
                               : (map_rdata & ~run_mask(wcur, at, last));
      end
      S_INIT: begin
        map_req.wr_en = 1'b1;
        map_req.addr  = wcur;
        map_req.wdata = init_word;
      end
      default: ;
    endcase
  end

  assign busy            = (state != S_IDLE);
  assign used_page_total = used_pages;
  assign alloc_total     = alloc_counter;
  assign free_total      = free_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      done           <= 1'b0;
      status         <= ST_DONE;
      start_page     <= '0;
      total_pages    <= 11'd1024;
      reserved_pages <= 10'd1;
      used_pages     <= '0;
      alloc_counter  <= '0;
      free_counter   <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_TOTAL)    total_pages    <= cfg_data;
        if (cfg_index == CFG_RESERVED) reserved_pages <= cfg_data[9:0];
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cnt   <= cnt_in;
            align <= align_in;
            case (req_type)
              REQ_ALLOC: begin
                if (!alloc_ok) begin
                  done <= 1'b1; status <= ST_BAD; start_page <= '0;
                end else if (at0 + cnt_in > limit) begin
                  done <= 1'b1; status <= ST_NO_RUN; start_page <= '0;
                end else begin
                  at     <= at0;
                  pos    <= at0;
                  op_set <= 1'b1;
                  state  <= S_SRCH_RD;
                end
              end
              REQ_FREE: begin
                if (!free_ok) begin
                  done <= 1'b1; status <= ST_BAD; start_page <= '0;
                end else begin
                  at     <= idx_in;
                  wcur   <= page_index[BIT_W+WORD_W-1:BIT_W];
                  op_set <= 1'b0;
                  state  <= S_MARK_RD;
                end
              end
              REQ_INIT: begin
                wcur  <= '0;
                state <= S_INIT;
              end
              default: begin
                done <= 1'b1; status <= ST_BAD; start_page <= '0;
              end
            endcase
          end
        end
        S_SRCH_RD: state <= S_SRCH_EX;
        S_SRCH_EX: begin
          if (hits != '0) begin
            // used page inside candidate: restart at next aligned start
            if (next_at + cnt > limit) begin
              done <= 1'b1; status <= ST_NO_RUN; start_page <= '0;
              state <= S_IDLE;
            end else begin
              at    <= next_at;
              pos   <= next_at;
              state <= S_SRCH_RD;
            end
          end else if (last[POS_W-1:BIT_W] == pos[POS_W-1:BIT_W]) begin
            wcur  <= at[BIT_W+WORD_W-1:BIT_W];
            state <= S_MARK_RD;
          end else begin
            pos   <= {pos[POS_W-1:BIT_W] + HI_W'(1), BIT_W'(0)};
            state <= S_SRCH_RD;
          end
        end
        S_MARK_RD: state <= S_MARK_WR;
        S_MARK_WR: begin
          if (wcur == last_word) begin
            done   <= 1'b1;
            status <= ST_DONE;
            state  <= S_IDLE;
            if (op_set) begin
              used_pages    <= used_inc;
              alloc_counter <= alloc_counter + 32'd1;
              start_page    <= at[PAGE_W-1:0];
            end else begin
              used_pages   <= used_dec;
              free_counter <= free_counter + 32'd1;
              start_page   <= '0;
            end
          end else begin
            wcur  <= wcur + WORD_W'(1);
            state <= S_MARK_RD;
          end
        end
        S_INIT: begin
          if (wcur == WORD_W'(MAP_WORDS - 1)) begin
            done          <= 1'b1;
            status        <= ST_DONE;
            start_page    <= '0;
            used_pages    <= init_r[10:0];
            alloc_counter <= '0;
            free_counter  <= '0;
            state         <= S_IDLE;
          end else begin
            wcur <= wcur + WORD_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result beat never overlaps a request in flight
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");

  // only a successful allocate reports a nonzero start page
  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_DONE) |-> (start_page == '0))
    else $error("start_page set on failed request");

  // an accepted request either answers at once or keeps the block busy
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("request dropped");

  // map is never read and written in the same cycle
  a_map_port: assert property (@(posedge clk) disable iff (rst)
    !(map_req.rd_en && map_req.wr_en))
    else $error("map port conflict");

endmodule
`default_nettype wire

### rtl/apra_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
`default_nettype none
module apra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/apra_map.sv
// Used-page map: word RAM plus per-word valid bits so reset reads as all free.
// Depends on apra_pkg and apra_ram.
`default_nettype none
module apra_map
  import apra_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire map_req_t req,
  output word_t         rdata
);

  logic [MAP_WORDS-1:0] word_valid;
  logic                 rd_valid;
  word_t                ram_q;

  apra_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (req.wr_en),
    .waddr(req.addr),
    .wdata(req.wdata),
    .raddr(req.addr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (req.wr_en) word_valid[req.addr] <= 1'b1;
      if (req.rd_en) rd_valid <= word_valid[req.addr];
    end
  end

  assign rdata = rd_valid ? ram_q : '0;

endmodule
`default_nettype wire

### bench/aligned_page_run_allocator_test.sv
// Testbench for aligned_page_run_allocator: directed and random request beats
// checked against an in-bench predictor of the used map. Depends on apra_pkg.
`default_nettype none
module aligned_page_run_allocator_test;
  import apra_pkg::*;

  // type 3 is not a request; the block must reject it
  localparam logic [1:0] REQ_UNDEF = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 20_000_000;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  start_page;
    logic [10:0] used_pages;
    logic [31:0] allocs;
    logic [31:0] frees;
  } reply_t;

  typedef struct {
    int unsigned first;
    int unsigned count;
  } run_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  req_type = '0;
  logic [10:0] page_count = '0;
  logic [10:0] run_align = '0;
  logic [9:0]  page_index = '0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [9:0]  start_page;
  logic [10:0] used_page_total;
  logic [31:0] alloc_total;
  logic [31:0] free_total;

  aligned_page_run_allocator u_dut (
    .clk, .rst, .start, .busy, .req_type, .page_count, .run_align, .page_index,
    .cfg_we, .cfg_index, .cfg_data, .done, .status, .start_page,
    .used_page_total, .alloc_total, .free_total
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state: one bit per page plus counters and registers
  logic [MAX_PAGES-1:0] page_map;
  logic [10:0]          used_cnt;
  logic [31:0]          alloc_cnt;
  logic [31:0]          free_cnt;
  logic [10:0]          pool_total;
  logic [9:0]           pool_reserved;

  reply_t      pending_replies[$];
  run_t        live_runs[$];
  int unsigned error_count = 0;
  int unsigned beats_sent = 0;
  int unsigned replies_seen = 0;
  int unsigned allocs_ok = 0;
  int unsigned allocs_full = 0;
  int unsigned cycle_count = 0;
  bit          steady = 1'b0;   // no idling in the closing stretch

  function automatic int unsigned align_up(int unsigned v, int unsigned a);
    return (v + a - 1) & ~(a - 1);
  endfunction

  // first-fit search and the state update for one request
  function automatic reply_t predict_request(logic [1:0] kind, logic [10:0] cnt,
                                             logic [10:0] aln, logic [9:0] idx);
    reply_t      r;
    int unsigned lim;
    int unsigned at;
    int unsigned k;
    int unsigned n;
    int unsigned found;
    run_t        run;
    r = '0;
    r.status = ST_BAD;
    lim = (pool_total > MAX_PAGES) ? MAX_PAGES : pool_total;
    n = cnt;
    case (kind)
      REQ_ALLOC: begin
        if (cnt != 0 && aln != 0 && (aln & (aln - 1)) == 0) begin
          found = 0;
          at = align_up(pool_reserved, aln);
          while (!found && at + n <= lim) begin
            k = 0;
            while (k < n && !page_map[at + k]) k++;
            if (k == n) found = 1;
            else at = align_up(at + k + 1, aln);
          end
          if (!found) begin
            r.status = ST_NO_RUN;
            allocs_full++;
          end else begin
            for (int i = 0; i < n; i++) page_map[at + i] = 1'b1;
            used_cnt = (used_cnt + n > 2047) ? 11'd2047 : 11'(used_cnt + n);
            alloc_cnt++;
            allocs_ok++;
            r.status = ST_DONE;
            r.start_page = 10'(at);
            run.first = at;
            run.count = n;
            live_runs.push_back(run);
          end
        end
      end
      REQ_FREE: begin
        if (cnt != 0 && idx < lim && idx + n <= lim) begin
          for (int i = 0; i < n; i++) page_map[idx + i] = 1'b0;
          used_cnt = (used_cnt > n) ? 11'(used_cnt - n) : 11'd0;
          free_cnt++;
          r.status = ST_DONE;
        end
      end
      REQ_INIT: begin
        k = (pool_reserved < lim) ? pool_reserved : lim;
        page_map = '0;
        for (int i = 0; i < k; i++) page_map[i] = 1'b1;
        used_cnt = 11'(k);
        alloc_cnt = '0;
        free_cnt = '0;
        live_runs.delete();
        r.status = ST_DONE;
      end
      default: ;
    endcase
    r.used_pages = used_cnt;
    r.allocs = alloc_cnt;
    r.frees = free_cnt;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("MISMATCH reply %0d %s: got %0d expected %0d", replies_seen, what, got, want);
  endtask

  // result beats: the receiver never stalls, so every done cycle is checked
  always @(posedge clk) begin
    reply_t want;
    if (!rst && done) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        error_count++;
        $display("MISMATCH unexpected reply beat, status %0d", status);
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (start_page !== want.start_page)
          report_mismatch("start_page", start_page, want.start_page);
        if (used_page_total !== want.used_pages)
          report_mismatch("used_page_total", used_page_total, want.used_pages);
        if (alloc_total !== want.allocs) report_mismatch("alloc_total", alloc_total, want.allocs);
        if (free_total !== want.frees) report_mismatch("free_total", free_total, want.frees);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // drive one request beat and hold it until the block takes it;
  // start is left high after the beat is taken; the next call sets it again
  task automatic send_request(logic [1:0] kind, logic [10:0] cnt, logic [10:0] aln,
                              logic [9:0] idx);
    req_type <= kind;
    page_count <= cnt;
    run_align <= aln;
    page_index <= idx;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_replies.push_back(predict_request(kind, cnt, aln, idx));
    beats_sent++;
  endtask

  task automatic maybe_pause();
    if (!steady && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // let every reply come home, then a few quiet cycles
  task automatic drain();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write enable stays high; the caller drops it after the last write
  task automatic write_reg(logic [0:0] which, logic [10:0] value);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    @(posedge clk);
    if (which == CFG_TOTAL) pool_total = value;
    else pool_reserved = value[9:0];
  endtask

  task automatic set_pool(logic [10:0] total, logic [9:0] reserved);
    drain();
    write_reg(CFG_TOTAL, total);
    write_reg(CFG_RESERVED, {1'b0, reserved});
    cfg_we <= 1'b0;
  endtask

  // directed edges: reset-state allocate, bad operands, full pool, odd frees
  task automatic test_directed_cases();
    send_request(REQ_ALLOC, 11'd1, 11'd1, '0);       // before init: page 0 unmarked
    send_request(REQ_INIT, '0, '0, '0);
    send_request(REQ_ALLOC, 11'd0, 11'd1, '0);       // zero count
    send_request(REQ_ALLOC, 11'd4, 11'd0, '0);       // zero alignment
    send_request(REQ_ALLOC, 11'd4, 11'd3, '0);       // not a power of two
    send_request(REQ_ALLOC, 11'd4, 11'd2047, '0);
    send_request(REQ_ALLOC, 11'd1, 11'd1024, '0);    // only start 1024: no room
    send_request(REQ_ALLOC, 11'd1024, 11'd1, '0);    // bigger than what is left
    send_request(REQ_ALLOC, 11'd1023, 11'd1, '0);    // fills the pool
    send_request(REQ_ALLOC, 11'd1, 11'd1, '0);
    send_request(REQ_FREE, 11'd0, '0, 10'd5);        // zero count
    send_request(REQ_FREE, 11'd2, '0, 10'd1023);     // runs past the end
    send_request(REQ_FREE, 11'd2047, '0, '0);
    send_request(REQ_FREE, 11'd1024, '0, '0);        // whole pool, reserved page too
    send_request(REQ_FREE, 11'd8, '0, 10'd100);      // pages already free
    send_request(REQ_UNDEF, 11'd5, 11'd1, 10'd3);
    send_request(REQ_ALLOC, 11'd3, 11'd8, '0);
    send_request(REQ_ALLOC, 11'd2, 11'd8, '0);       // skips past the used run
    send_request(REQ_ALLOC, 11'd64, 11'd64, '0);
    set_pool(11'd2047, 10'd0);                       // total clamps to the map size
    send_request(REQ_INIT, '0, '0, '0);
    send_request(REQ_ALLOC, 11'd1024, 11'd1024, '0);
    set_pool(11'd4, 10'd1023);                       // reserved beyond the pool
    send_request(REQ_INIT, '0, '0, '0);
    send_request(REQ_ALLOC, 11'd1, 11'd1, '0);
    send_request(REQ_FREE, 11'd4, '0, '0);
  endtask

  // mostly allocates and frees of live runs, with some noise
  task automatic test_random_traffic(int unsigned beats, logic [10:0] total,
                                     logic [9:0] reserved);
    int unsigned pick;
    int unsigned slot;
    run_t        run;
    logic [10:0] cnt;
    set_pool(total, reserved);
    send_request(REQ_INIT, '0, '0, '0);
    repeat (beats) begin
      maybe_pause();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        cnt = ($urandom_range(0, 19) == 0) ? 11'($urandom_range(1, 1024))
                                          : 11'($urandom_range(1, 16));
        send_request(REQ_ALLOC, cnt,
                     11'(1) << (($urandom_range(0, 3) == 0) ? $urandom_range(0, 10)
                                                             : $urandom_range(0, 3)),
                     10'($urandom));
      end else if (pick < 80 && live_runs.size() != 0) begin
        slot = $urandom_range(0, live_runs.size() - 1);
        run = live_runs[slot];
        live_runs.delete(slot);
        send_request(REQ_FREE, 11'(run.count), 11'($urandom), 10'(run.first));
      end else if (pick < 88) begin
        send_request(REQ_FREE, 11'($urandom_range(0, 40)), 11'($urandom), 10'($urandom));
      end else if (pick < 91) begin
        send_request(REQ_INIT, 11'($urandom), 11'($urandom), 10'($urandom));
      end else begin
        send_request(2'($urandom), 11'($urandom), 11'($urandom), 10'($urandom));
      end
    end
  endtask

  initial begin
    page_map = '0;
    used_cnt = '0;
    alloc_cnt = '0;
    free_cnt = '0;
    pool_total = 11'd1024;
    pool_reserved = 10'd1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_random_traffic(400, 11'd1024, 10'd1);
    test_random_traffic(300, 11'd2047, 10'd0);
    test_random_traffic(250, 11'd4, 10'd0);
    test_random_traffic(300, 11'd100, 10'd3);
    test_random_traffic(150, 11'd1024, 10'd1023);
    test_random_traffic(300, 11'd700, 10'd17);
    steady = 1'b1;
    test_random_traffic(300, 11'd1024, 10'd1);
    drain();
    $display("Covered %0d request beats, %0d replies: %0d allocations placed, %0d refused",
             beats_sent, replies_seen, allocs_ok, allocs_full);
    $display("Pool sizes 4 to 2047 pages, reserved 0 to 1023, idle gaps on both sides");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
rtl/apra_pkg.sv
rtl/apra_ram.sv
rtl/apra_map.sv
rtl/aligned_page_run_allocator.sv
bench/aligned_page_run_allocator_test.sv
